@@ rtl/ramr_pkg.sv @@
// shared constants and types for the rational add/multiply/reduce block
package ramr_pkg;

  // default operand width and fixed result widths
  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int NUMER_OUT_W       = 33;
  localparam int DENOM_OUT_W       = 32;

  // operation codes
  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_ADD_RED = 2'd1,
    OP_MUL     = 2'd2,
    OP_MUL_RED = 2'd3
  } opcode_t;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_MUL      = 6'b000010,
    ST_GCD_CHK  = 6'b000100,
    ST_GCD_WAIT = 6'b001000,
    ST_RED_DEN  = 6'b010000,
    ST_RED_NUM  = 6'b100000
  } state_t;

endpackage

@@ rtl/ramr_mul.sv @@
// shared signed multiplier with registered product
module ramr_mul #(
  parameter int WIDTH = 16
) (
  input  logic                      clk,
  input  logic signed [WIDTH-1:0]   a,
  input  logic signed [WIDTH-1:0]   b,
  output logic signed [2*WIDTH-1:0] p
);

  // one product per cycle, product registered
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

@@ rtl/ramr_div.sv @@
// shared iterative signed divider, truncating quotient and remainder
module ramr_div #(
  parameter int WIDTH = 33
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [WIDTH-1:0] dividend,
  input  logic signed [WIDTH-1:0] divisor,
  output logic signed [WIDTH-1:0] quot,
  output logic signed [WIDTH-1:0] rem,
  output logic                    done
);

  localparam int CW = $clog2(WIDTH);

  logic          active;
  logic [CW-1:0] cnt;
  logic [WIDTH-1:0] qmag;
  logic [WIDTH-1:0] rmag;
  logic [WIDTH-1:0] dmag;
  logic          q_neg;
  logic          r_neg;

  logic [WIDTH:0]   rsh;
  logic             fits;
  logic [WIDTH:0]   rsub;

  // one restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    rsh  = {rmag, qmag[WIDTH-1]};
    fits = (rsh >= {1'b0, dmag});
    rsub = rsh - {1'b0, dmag};
  end

  // load magnitudes on start, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        qmag   <= dividend[WIDTH-1] ? WIDTH'(-dividend) : WIDTH'(dividend);
        dmag   <= divisor[WIDTH-1] ? WIDTH'(-divisor) : WIDTH'(divisor);
        rmag   <= '0;
        q_neg  <= dividend[WIDTH-1] ^ divisor[WIDTH-1];
        r_neg  <= dividend[WIDTH-1];
      end else if (active) begin
        rmag <= fits ? rsub[WIDTH-1:0] : rsh[WIDTH-1:0];
        qmag <= {qmag[WIDTH-2:0], fits};
        cnt  <= cnt + CW'(1);
        if (cnt == CW'(WIDTH - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // signs follow truncating division
  assign quot = q_neg ? -$signed(qmag) : $signed(qmag);
  assign rem  = r_neg ? -$signed(rmag) : $signed(rmag);

endmodule

@@ rtl/rational_add_mul_reduce.sv @@
// Rational add/multiply with optional gcd reduction, one shared multiplier and divider.
// Unreduced ops: done is registered from the last of the 4 products taken in ST_MUL.
// Reduced ops: with EW = 2*OPERAND_WIDTH + 1 bits (64 at most), each Euclid step is one EW-bit
// division, then den and num are divided by the gcd in turn; a zero gcd finishes at the check.
// busy holds from the accepted start until the cycle done shows; the next start may come then.
// Synchronous reset returns the sequencer to idle and clears done.
module rational_add_mul_reduce import ramr_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      opcode,
  input  logic signed [OPERAND_WIDTH-1:0] numer_a,
  input  logic signed [OPERAND_WIDTH-1:0] denom_a,
  input  logic signed [OPERAND_WIDTH-1:0] numer_b,
  input  logic signed [OPERAND_WIDTH-1:0] denom_b,
  output logic                            done,
  output logic signed [NUMER_OUT_W-1:0]   numer_out,
  output logic signed [DENOM_OUT_W-1:0]   denom_out,
  output logic                            zero_gcd
);

  localparam int W   = OPERAND_WIDTH;
  localparam int PW  = 2 * W;
  localparam int EW  = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
  localparam int XNW = (EW > NUMER_OUT_W) ? EW : NUMER_OUT_W;
  localparam int XDW = (EW > DENOM_OUT_W) ? EW : DENOM_OUT_W;

  state_t  state;
  logic [2:0] step;
  opcode_t op;
  logic signed [W-1:0] na, da, nb, db;
  logic signed [EW-1:0] num, den, x, y;

  logic is_add, is_red;
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [EW-1:0] pe, num_cur;

  logic                 div_start, div_done;
  logic signed [EW-1:0] div_a, div_b, div_quot, div_rem;

  logic                 fin_go, fin_zero;
  logic signed [EW-1:0] fin_num, fin_den;
  logic signed [XNW-1:0] num_x;
  logic signed [XDW-1:0] den_x;

  assign is_add = (op == OP_ADD) || (op == OP_ADD_RED);
  assign is_red = (op == OP_ADD_RED) || (op == OP_MUL_RED);
  assign busy   = (state != ST_IDLE);

  // operand select for the shared multiplier
  always_comb begin
    case (step)
      3'd0:    begin mul_a = na; mul_b = db; end
      3'd1:    begin mul_a = da; mul_b = nb; end
      3'd2:    begin mul_a = da; mul_b = db; end
      default: begin mul_a = na; mul_b = nb; end
    endcase
  end

  ramr_mul #(.WIDTH(W)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign pe      = EW'(mul_p);
  assign num_cur = is_add ? num : pe;

  // divider requests: euclid remainder, then both parts by the gcd
  always_comb begin
    div_start = 1'b0;
    div_a     = x;
    div_b     = y;
    unique case (state)
      ST_GCD_CHK: begin
        if (y != '0) begin
          div_start = 1'b1;
        end else if (x != '0) begin
          div_start = 1'b1;
          div_a     = den;
          div_b     = x;
        end
      end
      ST_RED_DEN: begin
        div_start = div_done;
        div_a     = num;
        div_b     = x;
      end
      ST_IDLE, ST_MUL, ST_GCD_WAIT, ST_RED_NUM: begin
        div_start = 1'b0;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  ramr_div #(.WIDTH(EW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quot     (div_quot),
    .rem      (div_rem),
    .done     (div_done)
  );

  // result word selection
  always_comb begin
    fin_go   = 1'b0;
    fin_zero = 1'b0;
    fin_num  = num;
    fin_den  = den;
    unique case (state)
      ST_MUL: begin
        if (step == 3'd4 && !is_red) begin
          fin_go  = 1'b1;
          fin_num = num_cur;
        end
      end
      ST_GCD_CHK: begin
        if (y == '0 && x == '0) begin
          fin_go   = 1'b1;
          fin_zero = 1'b1;
          fin_num  = '0;
          fin_den  = '0;
        end
      end
      ST_RED_NUM: begin
        if (div_done) begin
          fin_go  = 1'b1;
          fin_num = div_quot;
        end
      end
      ST_IDLE, ST_GCD_WAIT, ST_RED_DEN: begin
        fin_go = 1'b0;
      end
      default: begin
        fin_go = 1'b0;
      end
    endcase
  end

  assign num_x = XNW'(fin_num);
  assign den_x = XDW'(fin_den);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= fin_go;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            op    <= opcode_t'(opcode);
            na    <= numer_a;
            da    <= denom_a;
            nb    <= numer_b;
            db    <= denom_b;
            step  <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          step <= step + 3'd1;
          case (step)
            3'd1:    num <= pe;
            3'd2:    if (is_add) num <= num + pe;
            3'd3:    den <= pe;
            3'd4:    if (!is_add) num <= pe;
            default: ;
          endcase
          if (step == 3'd4) begin
            x     <= den;
            y     <= num_cur;
            state <= is_red ? ST_GCD_CHK : ST_IDLE;
          end
        end
        ST_GCD_CHK: begin
          if (y != '0) begin
            state <= ST_GCD_WAIT;
          end else if (x == '0) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_RED_DEN;
          end
        end
        ST_GCD_WAIT: begin
          if (div_done) begin
            x     <= y;
            y     <= div_rem;
            state <= ST_GCD_CHK;
          end
        end
        ST_RED_DEN: begin
          if (div_done) begin
            den   <= div_quot;
            state <= ST_RED_NUM;
          end
        end
        ST_RED_NUM: begin
          if (div_done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result word registers
  always_ff @(posedge clk) begin
    if (fin_go) begin
      numer_out <= num_x[NUMER_OUT_W-1:0];
      denom_out <= den_x[DENOM_OUT_W-1:0];
      zero_gcd  <= fin_zero;
    end
  end

endmodule
